### rtl/fbpa_pkg.sv
// Shared types, codes and sizes for the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = 9;
    localparam int ADDR_W       = 32;
    localparam int WORDS_W      = 14;
    localparam int BYTES_W      = WORDS_W + 2;
    localparam int DIV_STEPS    = ADDR_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int MIN_WORDS    = 2;
    localparam int REG_IDX_W    = 2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE   = 2'd0,
        REG_WORDS  = 2'd1,
        REG_COUNT  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_DIVIDE,
        ST_CHECK,
        ST_POP,
        ST_MULT,
        ST_RESULT
    } state_t;

endpackage

### rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: sequencer, shared adder and return stack.
//
// Fixed block pool allocator. One transaction in gives one transaction out. An allocate pops
// the most recently freed block index from a return stack (a 256 x 8 RAM), or else takes the
// next never-used block, then forms base + index * block_bytes with the shared 33-bit
// add/subtract unit over 8 shift-add steps; a popped index first passes a stack read state,
// and an empty pool goes straight to the result. A free subtracts the base, then runs a
// 32-step restoring division of the offset by the block size on the same unit to check
// range and alignment and recover the index. The division sets the free latency; the block
// accepts one transaction at a time and input ready stays low until the result is in the
// output register, which holds it until taken while the next transaction may already be
// accepted. The stack RAM needs no clearing pass: only entries below the stack depth are
// read. Writing any configuration register empties the pool back to all free; write it
// only while idle.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [0:0]            opcode,
    input  logic [ADDR_W-1:0]     address,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     block_address,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      free_count,
    output logic                  all_returned,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data
);

    localparam int MULT_STEPS = IDX_W;

    // control state
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic                out_valid_reg, out_valid_next;
    // configuration
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [WORDS_W-1:0]  words_reg, words_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    // datapath payload
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   acc_reg, acc_next;       // product accumulator, or dividend/quotient
    logic [ADDR_W-1:0]   mcand_reg, mcand_next;
    logic [BYTES_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    status_t             res_status_reg, res_status_next;
    logic                res_alloc_reg, res_alloc_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;
    logic                out_all_reg, out_all_next;

    // shared add/subtract unit
    logic [ADDR_W-1:0]   alu_a, alu_b, alu_b_eff;
    logic                alu_sub;
    logic [ADDR_W:0]     alu_sum;
    logic                alu_carry;

    // return stack
    logic                ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr, ram_wr_data, ram_rd_data;

    logic                in_fire, cfg_fire, out_slot_free;
    logic [BYTES_W-1:0]  block_bytes;
    logic [CNT_W-1:0]    depth_dec, free_now;
    logic                free_ok;
    logic [WORDS_W-1:0]  cfg_words;
    logic [CNT_W-1:0]    cfg_count;

    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = in_valid && in_ready;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_slot_free = !out_valid_reg || out_ready;
    assign block_bytes   = {words_reg, 2'b00};
    assign depth_dec     = depth_reg - CNT_W'(1);
    assign free_now      = depth_reg + (count_reg - fresh_reg);

    assign out_valid     = out_valid_reg;
    assign block_address = out_addr_reg;
    assign status        = out_status_reg;
    assign free_count    = out_free_reg;
    assign all_returned  = out_all_reg;

    // Clamp configuration values into their legal ranges.
    assign cfg_words = (cfg_data[WORDS_W-1:0] < WORDS_W'(MIN_WORDS)) ?
                       WORDS_W'(MIN_WORDS) : cfg_data[WORDS_W-1:0];
    always_comb
    begin
        cfg_count = cfg_data[CNT_W-1:0];
        if (cfg_count == '0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (cfg_count > CNT_W'(MAX_BLOCKS))
        begin
            cfg_count = CNT_W'(MAX_BLOCKS);
        end
    end

    // Free is accepted when the quotient lies inside the pool, the remainder is zero,
    // at least one block is out, and the stack has room.
    assign free_ok = (acc_reg[ADDR_W-1:CNT_W] == '0) && (acc_reg[CNT_W-1:0] < count_reg)
                     && (rem_reg == '0) && (free_now < count_reg)
                     && (depth_reg < CNT_W'(MAX_BLOCKS));

    // Operand select for the shared unit.
    always_comb
    begin
        alu_a   = mcand_reg;
        alu_b   = acc_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_OFFSET:
            begin
                alu_a   = addr_reg;
                alu_b   = base_reg;
                alu_sub = 1'b1;
            end
            ST_DIVIDE:
            begin
                alu_a   = ADDR_W'({rem_reg, acc_reg[ADDR_W-1]});
                alu_b   = ADDR_W'(block_bytes);
                alu_sub = 1'b1;
            end
            ST_IDLE, ST_CHECK, ST_POP, ST_MULT, ST_RESULT:
            begin
                alu_a   = mcand_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = mcand_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b_eff} + (ADDR_W+1)'(alu_sub);
    assign alu_carry = alu_sum[ADDR_W];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (opcode == OP_FREE)
                    begin
                        state_next = ST_OFFSET;
                    end
                    else if (depth_reg != '0)
                    begin
                        state_next = ST_POP;
                    end
                    else if (fresh_reg < count_reg)
                    begin
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_OFFSET:
            begin
                state_next = alu_carry ? ST_DIVIDE : ST_RESULT;
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_RESULT;
            end
            ST_POP:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (step_reg == STEP_W'(MULT_STEPS - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and bookkeeping.
    always_comb
    begin
        step_next       = step_reg + STEP_W'(1);
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        base_next       = base_reg;
        words_next      = words_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_alloc_next  = res_alloc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_all_next    = out_all_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = depth_reg[IDX_W-1:0];
        ram_wr_data     = acc_reg[IDX_W-1:0];
        ram_rd_en       = 1'b0;
        ram_rd_addr     = depth_dec[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next       = '0;
                addr_next       = address;
                acc_next        = base_reg;
                mcand_next      = ADDR_W'(block_bytes);
                res_status_next = STATUS_OK;
                res_alloc_next  = (opcode == OP_ALLOC);
                if (in_fire && (opcode == OP_ALLOC))
                begin
                    priority if (depth_reg != '0)
                    begin
                        // pop the most recently returned block
                        ram_rd_en  = 1'b1;
                        depth_next = depth_dec;
                    end
                    else if (fresh_reg < count_reg)
                    begin
                        idx_next   = fresh_reg[IDX_W-1:0];
                        fresh_next = fresh_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                end
            end
            ST_OFFSET:
            begin
                // dividend = address - base; below base is invalid
                step_next = '0;
                acc_next  = alu_sum[ADDR_W-1:0];
                rem_next  = '0;
                if (!alu_carry)
                begin
                    res_status_next = STATUS_INVALID;
                end
            end
            ST_DIVIDE:
            begin
                // one restoring division step: shift in, trial subtract, keep if no borrow
                if (alu_carry)
                begin
                    rem_next = alu_sum[BYTES_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[BYTES_W-2:0], acc_reg[ADDR_W-1]};
                end
                acc_next = {acc_reg[ADDR_W-2:0], alu_carry};
            end
            ST_CHECK:
            begin
                if (free_ok)
                begin
                    ram_wr_en  = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                end
                else
                begin
                    res_status_next = STATUS_INVALID;
                end
            end
            ST_POP:
            begin
                step_next = '0;
                idx_next  = ram_rd_data;
            end
            ST_MULT:
            begin
                // shift-add: acc += bytes << i when bit i of the index is set
                if (idx_reg[0])
                begin
                    acc_next = alu_sum[ADDR_W-1:0];
                end
                idx_next   = idx_reg >> 1;
                mcand_next = mcand_reg << 1;
            end
            ST_RESULT:
            begin
                if (out_slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = (res_alloc_reg && (res_status_reg == STATUS_OK)) ?
                                      acc_reg : '0;
                    out_free_next   = free_now;
                    out_all_next    = (free_now == count_reg);
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase

        // Any write to a known register returns the whole pool.
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_BASE:
                begin
                    base_next  = cfg_data;
                    depth_next = '0;
                    fresh_next = '0;
                end
                REG_WORDS:
                begin
                    words_next = cfg_words;
                    depth_next = '0;
                    fresh_next = '0;
                end
                REG_COUNT:
                begin
                    count_next = cfg_count;
                    depth_next = '0;
                    fresh_next = '0;
                end
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            words_reg     <= WORDS_W'(MIN_WORDS);
            count_reg     <= CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            words_reg     <= words_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_alloc_reg  <= res_alloc_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        out_all_reg    <= out_all_next;
    end

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

### rtl/fbpa_checker.sv
// Port-level assertions for the fixed block pool allocator, bound to the top level.
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] block_address,
    input logic [1:0]        status,
    input logic [CNT_W-1:0]  free_count,
    input logic              all_returned
);

    // A held result does not change until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_address) && $stable(status))
        else $error("result changed while stalled");

    // One transaction at a time: busy in the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Failed requests return no address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY || status == STATUS_INVALID) |-> block_address == '0)
        else $error("address returned on failed request");

    // Empty pool means nothing free.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |-> free_count == '0 && !all_returned)
        else $error("empty reported with free blocks");

    // Status stays within its codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_EMPTY || status == STATUS_INVALID)
        else $error("undefined status code");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_address (block_address),
    .status        (status),
    .free_count    (free_count),
    .all_returned  (all_returned)
);

### tb/fixed_block_pool_allocator_test.sv
// Self-checking testbench for the fixed block pool allocator.
module fixed_block_pool_allocator_test
    import fbpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits and stall lengths
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 48;
    localparam int unsigned PHASE_ITEMS  = 155;
    localparam int unsigned PHASE_COUNT  = 6;
    localparam int unsigned SCRIPT_LEN   = 35;

    // Register index with no register behind it; the block ignores the write
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One result transaction as the block should produce it
    typedef struct packed {
        logic [ADDR_W-1:0] blk_addr;
        status_t           st;
        logic [CNT_W-1:0]  free_n;
        logic              all_free;
    } pool_result_t;

    // One line of the directed script: a register write or a request
    typedef struct packed {
        logic                 is_write;
        logic [REG_IDX_W-1:0] reg_sel;
        logic [ADDR_W-1:0]    data;
        opcode_t              op;
        logic                 typed;
        pool_result_t         want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [0:0]           opcode = OP_ALLOC;
    logic [ADDR_W-1:0]    address = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    block_address;
    logic [1:0]           status;
    logic [CNT_W-1:0]     free_count;
    logic                 all_returned;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    fixed_block_pool_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_address (block_address),
        .status        (status),
        .free_count    (free_count),
        .all_returned  (all_returned),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Pool predictor: its own copy of the registers and the free-block state
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  pool_base;
    logic [WORDS_W-1:0] pool_words;
    logic [CNT_W-1:0]   pool_count;
    logic [IDX_W-1:0]   freed_stack [MAX_BLOCKS];
    logic [CNT_W-1:0]   freed_depth;
    logic [CNT_W-1:0]   fresh_idx;

    pool_result_t pending_results [$];   // results still owed by the block, oldest first
    pool_result_t head;
    int unsigned  mismatches = 0;

    // Stimulus shaping
    int unsigned in_idle_pct = 0;
    int unsigned out_idle_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;
    int unsigned alloc_pct = 50;

    script_row_t script [SCRIPT_LEN];

    function automatic void pool_reset();
        pool_base   = '0;
        pool_words  = WORDS_W'(MIN_WORDS);
        pool_count  = CNT_W'(MAX_BLOCKS);
        freed_depth = '0;
        fresh_idx   = '0;
    endfunction

    function automatic logic [CNT_W-1:0] pool_free_blocks();
        return freed_depth + (pool_count - fresh_idx);
    endfunction

    // Any known register write restores the whole pool to free
    function automatic void pool_configure(logic [REG_IDX_W-1:0] sel, logic [ADDR_W-1:0] value);
        logic [WORDS_W-1:0] w;
        logic [CNT_W-1:0]   c;
        case (sel)
            REG_BASE: pool_base = value;
            REG_WORDS:
            begin
                w = value[WORDS_W-1:0];
                pool_words = (w < MIN_WORDS) ? WORDS_W'(MIN_WORDS) : w;
            end
            REG_COUNT:
            begin
                c = value[CNT_W-1:0];
                if (c == 0)
                    c = CNT_W'(1);
                if (c > MAX_BLOCKS)
                    c = CNT_W'(MAX_BLOCKS);
                pool_count = c;
            end
            default: return;
        endcase
        freed_depth = '0;
        fresh_idx   = '0;
    endfunction

    // Serve one request and advance the predicted pool state
    function automatic pool_result_t pool_serve(opcode_t op, logic [ADDR_W-1:0] addr);
        logic [63:0]      bytes;
        logic [63:0]      off;
        logic [63:0]      sum;
        logic [IDX_W-1:0] idx;
        logic             got;
        pool_result_t     r;
        bytes = {48'd0, pool_words, 2'b00};
        r = '0;
        r.st = STATUS_OK;
        got = 1'b0;
        idx = '0;
        if (op == OP_ALLOC)
        begin
            if (freed_depth != 0)
            begin
                freed_depth = freed_depth - CNT_W'(1);
                idx = freed_stack[freed_depth[IDX_W-1:0]];
                got = 1'b1;
            end
            else if (fresh_idx < pool_count)
            begin
                idx = fresh_idx[IDX_W-1:0];
                fresh_idx = fresh_idx + CNT_W'(1);
                got = 1'b1;
            end
            if (got)
            begin
                sum = {32'd0, pool_base} + {56'd0, idx} * bytes;
                r.blk_addr = sum[ADDR_W-1:0];
            end
            else
                r.st = STATUS_EMPTY;
        end
        else
        begin
            // Range and alignment are judged on the unwrapped pool span
            if (addr >= pool_base)
            begin
                off = {32'd0, addr} - {32'd0, pool_base};
                if (off < {55'd0, pool_count} * bytes && (off % bytes) == 0)
                begin
                    got = 1'b1;
                    idx = IDX_W'(off / bytes);
                end
            end
            // Reject a return when nothing is out
            if (got && pool_free_blocks() >= pool_count)
                got = 1'b0;
            if (got && freed_depth < MAX_BLOCKS)
            begin
                freed_stack[freed_depth[IDX_W-1:0]] = idx;
                freed_depth = freed_depth + CNT_W'(1);
            end
            else
                r.st = STATUS_INVALID;
        end
        r.free_n   = pool_free_blocks();
        r.all_free = (r.free_n == pool_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed script rows
    // ------------------------------------------------------------------
    function automatic script_row_t write_row(logic [REG_IDX_W-1:0] sel,
                                              logic [ADDR_W-1:0] value);
        script_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_sel  = sel;
        r.data     = value;
        return r;
    endfunction

    function automatic script_row_t request_row(opcode_t op, logic [ADDR_W-1:0] addr);
        script_row_t r;
        r = '0;
        r.op   = op;
        r.data = addr;
        return r;
    endfunction

    function automatic script_row_t checked_row(opcode_t op, logic [ADDR_W-1:0] addr,
                                                logic [ADDR_W-1:0] blk, status_t st,
                                                int unsigned n, logic all_free);
        script_row_t r;
        r = request_row(op, addr);
        r.typed          = 1'b1;
        r.want.blk_addr  = blk;
        r.want.st        = st;
        r.want.free_n    = CNT_W'(n);
        r.want.all_free  = all_free;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request and register channel drivers (all run in the stimulus process)
    // ------------------------------------------------------------------
    // Offer one request, hold it until taken, then record what it must return
    task automatic push_item(input opcode_t op, input logic [ADDR_W-1:0] addr,
                             input logic typed, input pool_result_t typed_want);
        pool_result_t predicted;
        opcode   <= op;
        address  <= addr;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = pool_serve(op, addr);
        pending_results.push_back(typed ? typed_want : predicted);
        // Idle the request side now and then; long gaps span the whole divide
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4)) @(posedge clk);
        end
    endtask

    // Leave cfg_valid high on return; the caller drops it after the last write
    task automatic write_reg(input logic [REG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] value);
        cfg_index <= sel;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        pool_configure(sel, value);
    endtask

    // Stop offering requests and wait until every owed result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned take_pct);
        in_idle_pct = send_pct;
        out_idle_pct <= take_pct;
    endtask

    // Mostly well-formed traffic: alloc and free bursts so the pool swings between
    // empty and fully returned; the rest is stray, misaligned or out-of-pool frees
    task automatic random_item();
        logic [63:0] bytes;
        logic [63:0] spot;
        int unsigned pick;
        bytes = {48'd0, pool_words, 2'b00};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(2))
                0: alloc_pct = 85;
                1: alloc_pct = 20;
                default: alloc_pct = 50;
            endcase
        end
        burst_left--;
        if ($urandom_range(99) < alloc_pct)
            push_item(OP_ALLOC, $urandom, 1'b0, '0);
        else
        begin
            pick = $urandom_range(99);
            spot = {32'd0, pool_base}
                 + 64'($urandom_range(int'(pool_count) - 1)) * bytes;
            if (pick < 10)
                spot = {32'd0, $urandom};
            else if (pick < 18)
                spot = spot + 64'($urandom_range(1, 32'(bytes - 1)));
            else if (pick < 24)
                spot = {32'd0, pool_base} + {55'd0, pool_count} * bytes;
            else if (pick < 28)
                spot = {32'd0, pool_base - 32'd4};
            push_item(OP_FREE, spot[ADDR_W-1:0], 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off, and the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected: addr %h status %0d",
                       block_address, status);
                mismatches++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (block_address !== head.blk_addr)
                begin
                    $error("block_address: expected %h, got %h", head.blk_addr, block_address);
                    mismatches++;
                end
                if (status !== head.st)
                begin
                    $error("status: expected %0d, got %0d", head.st, status);
                    mismatches++;
                end
                if (free_count !== head.free_n)
                begin
                    $error("free_count: expected %0d, got %0d", head.free_n, free_count);
                    mismatches++;
                end
                if (all_returned !== head.all_free)
                begin
                    $error("all_returned: expected %0b, got %0b", head.all_free, all_returned);
                    mismatches++;
                end
            end
        end
        // A hold-off request blocks the result side for a long stretch
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_done != hold_asks)
        begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Abort a hung run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic              prev_write;
        logic [ADDR_W-1:0] base_w;
        logic [ADDR_W-1:0] words_w;
        logic [ADDR_W-1:0] count_w;
        int unsigned       ph;
        int unsigned       n;

        // Reset pool: base 0, 8-byte blocks, 256 blocks
        script = '{
            checked_row(OP_ALLOC, 32'h0000_1234, 32'h0, STATUS_OK, 255, 1'b0),
            // misaligned, one past the end, far out of the pool
            checked_row(OP_FREE, 32'h0000_0004, 32'h0, STATUS_INVALID, 255, 1'b0),
            checked_row(OP_FREE, 32'h0000_0800, 32'h0, STATUS_INVALID, 255, 1'b0),
            checked_row(OP_FREE, 32'hFFFF_FFFF, 32'h0, STATUS_INVALID, 255, 1'b0),
            checked_row(OP_FREE, 32'h0000_0000, 32'h0, STATUS_OK, 256, 1'b1),
            // nothing is out, so a return is refused
            checked_row(OP_FREE, 32'h0000_0000, 32'h0, STATUS_INVALID, 256, 1'b1),
            // a count of zero is stored as one block
            write_row(REG_COUNT, 32'h0),
            checked_row(OP_ALLOC, 32'hFFFF_FFFF, 32'h0, STATUS_OK, 0, 1'b0),
            checked_row(OP_ALLOC, 32'h0000_0000, 32'h0, STATUS_EMPTY, 0, 1'b0),
            checked_row(OP_FREE, 32'h0000_0008, 32'h0, STATUS_INVALID, 0, 1'b0),
            checked_row(OP_FREE, 32'h0000_0000, 32'h0, STATUS_OK, 1, 1'b1),
            // undersized block clamps up, oversized count clamps down
            write_row(REG_WORDS, 32'h1),
            write_row(REG_COUNT, 32'h0000_03FF),
            request_row(OP_ALLOC, 32'h0),
            request_row(OP_FREE, 32'h0000_07F8),
            // pool that runs past the top of the address space
            write_row(REG_BASE, 32'hFFFF_FFFC),
            write_row(REG_WORDS, 32'hFFFF_FFFF),
            checked_row(OP_ALLOC, 32'h5A5A_A5A5, 32'hFFFF_FFFC, STATUS_OK, 255, 1'b0),
            request_row(OP_ALLOC, 32'h0),
            request_row(OP_FREE, 32'h0000_FFF8),
            request_row(OP_FREE, 32'hFFFF_FFFC),
            request_row(OP_ALLOC, 32'h0),
            request_row(OP_FREE, 32'hFFFF_FFFD),
            // three small blocks: exhaust, return one twice, reuse
            write_row(REG_BASE, 32'h0000_1000),
            write_row(REG_WORDS, 32'h2),
            write_row(REG_COUNT, 32'h3),
            checked_row(OP_ALLOC, 32'h0, 32'h0000_1000, STATUS_OK, 2, 1'b0),
            request_row(OP_ALLOC, 32'h0),
            request_row(OP_ALLOC, 32'h0),
            checked_row(OP_ALLOC, 32'h0, 32'h0, STATUS_EMPTY, 0, 1'b0),
            request_row(OP_FREE, 32'h0000_1008),
            request_row(OP_FREE, 32'h0000_1008),
            // write to an unmapped index must leave the pool untouched
            write_row(REG_UNUSED, 32'hFFFF_FFFF),
            request_row(OP_ALLOC, 32'h0),
            request_row(OP_FREE, 32'h0000_0FFC)
        };

        pool_reset();
        set_idling(19, 80);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed script; registers change only with the block idle
        prev_write = 1'b0;
        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                if (!prev_write)
                    drain();
                write_reg(script[i].reg_sel, script[i].data);
                prev_write = 1'b1;
            end
            else
            begin
                if (prev_write)
                    cfg_valid <= 1'b0;
                prev_write = 1'b0;
                push_item(script[i].op, script[i].data, script[i].typed, script[i].want);
            end
        end

        // Random phases, each under its own pool layout and idling mix
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    base_w  = $urandom & 32'hFFFF_FFFC;
                    words_w = $urandom_range(2, 6);
                    count_w = $urandom_range(2, 6);
                end
                1:
                begin
                    base_w  = 32'h0;
                    words_w = 32'd16383;
                    count_w = 32'd256;
                end
                2:
                begin
                    base_w  = $urandom & 32'hFFFF_FFFC;
                    words_w = 32'd0;
                    count_w = 32'd1;
                end
                3:
                begin
                    base_w  = 32'hFFFF_FFFC - 32'($urandom_range(0, 64)) * 4;
                    words_w = $urandom_range(2, 40);
                    count_w = $urandom_range(1, 16);
                end
                4:
                begin
                    base_w  = $urandom & 32'hFFFF_FFFC;
                    words_w = 32'd2;
                    count_w = 32'd256;
                end
                default:
                begin
                    base_w  = $urandom & 32'hFFFF_FFFC;
                    words_w = $urandom_range(2, 16383);
                    count_w = $urandom_range(1, 8);
                end
            endcase
            drain();
            write_reg(REG_BASE, base_w);
            write_reg(REG_WORDS, words_w);
            write_reg(REG_COUNT, count_w);
            cfg_valid <= 1'b0;

            if (ph < 2)
                set_idling(19, 80);
            else if (ph < 4)
                set_idling(80, 19);
            else
                set_idling(0, 0);
            // Block the result side while requests keep coming, so input stalls
            if (ph == 4)
                hold_asks <= hold_asks + 1;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item();
                // Pause the request side until the block has delivered everything
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
